// File: hdl/infix_to_postfix_converter_defines.svh
// Assertion macros used by the checker of the infix to postfix converter.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge and disabled during reset.
`define IPC_ASSERT_NOW(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("ipc checker: same-cycle rule violated");

// Next-cycle implication, sampled on the rising clock edge and disabled during reset.
`define IPC_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("ipc checker: next-cycle rule violated");

`endif

// File: hdl/ipc_pkg.sv
// Package for the infix to postfix converter: sizes, character codes, token and status
// codes, controller/datapath command and status structs, and character class functions.
// No dependencies.
package ipc_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
	localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
	localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
	localparam logic [7:0] CH_PLUS         = 8'h2B;
	localparam logic [7:0] CH_MINUS        = 8'h2D;
	localparam logic [7:0] CH_STAR         = 8'h2A;
	localparam logic [7:0] CH_SLASH        = 8'h2F;
	localparam logic [7:0] CH_DIGIT_0      = 8'h30;
	localparam logic [7:0] CH_DIGIT_9      = 8'h39;
	localparam logic [7:0] CH_UPPER_A      = 8'h41;
	localparam logic [7:0] CH_UPPER_Z      = 8'h5A;
	localparam logic [7:0] CH_LOWER_A      = 8'h61;
	localparam logic [7:0] CH_LOWER_Z      = 8'h7A;

	localparam logic [1:0] PREC_NONE = 2'd0;
	localparam logic [1:0] PREC_ADD  = 2'd1;
	localparam logic [1:0] PREC_MUL  = 2'd2;

	typedef enum logic [1:0] {
		TOK_DIGIT = 2'd0,
		TOK_CELL  = 2'd1,
		TOK_OP    = 2'd2,
		TOK_END   = 2'd3
	} tok_kind_t;

	typedef enum logic [1:0] {
		ST_OK               = 2'd0,
		ST_OVERFLOW         = 2'd1,
		ST_UNMATCHED_CLOSE  = 2'd2,
		ST_UNMATCHED_OPEN   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		EMIT_NONE = 2'd0,
		EMIT_PEND = 2'd1,
		EMIT_LAST = 2'd2
	} emit_mode_t;

	typedef struct packed {
		logic       capture;
		logic       hold_letter;
		logic       drop_letter;
		logic       push_ch;
		logic       pop;
		logic       end_expr;
		logic       flush;
		status_t    flag;
		emit_mode_t emit;
		tok_kind_t  kind;
	} dp_cmd_t;

	typedef struct packed {
		logic fin;
		logic letter_waiting;
		logic is_letter;
		logic is_digit;
		logic is_open;
		logic is_close;
		logic is_op;
		logic stack_empty;
		logic top_open;
		logic top_ge;
		logic pend_valid;
		logic slot_free;
	} dp_stat_t;

	function automatic logic is_open_char(input logic [7:0] c);
		return (c == CH_OPEN_PAREN) || (c == CH_OPEN_SQUARE) || (c == CH_OPEN_CURLY);
	endfunction

	function automatic logic is_close_char(input logic [7:0] c);
		return (c == CH_CLOSE_PAREN) || (c == CH_CLOSE_SQUARE) || (c == CH_CLOSE_CURLY);
	endfunction

	function automatic logic is_letter_char(input logic [7:0] c);
		return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
			((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
	endfunction

	function automatic logic is_digit_char(input logic [7:0] c);
		return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
	endfunction

	function automatic logic [1:0] op_prec(input logic [7:0] c);
		logic [1:0] p;
		p = PREC_NONE;
		if ((c == CH_STAR) || (c == CH_SLASH))
			p = PREC_MUL;
		else if ((c == CH_PLUS) || (c == CH_MINUS))
			p = PREC_ADD;
		return p;
	endfunction

endpackage

// File: hdl/ipc_char_if.sv
// Character request channel of the infix to postfix converter: valid, ready and one
// ASCII character with its last-character mark. No dependencies.
interface ipc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       final_char;

	modport source (output valid, output ch, output final_char, input ready);
	modport sink (input valid, input ch, input final_char, output ready);
endinterface

// File: hdl/ipc_tok_if.sv
// Token request channel of the infix to postfix converter: valid, ready and one postfix
// token with its end-of-run mark and status. No dependencies.
interface ipc_tok_if;
	logic       valid;
	logic       ready;
	logic [1:0] token_kind;
	logic [7:0] first_char;
	logic [7:0] second_char;
	logic       end_of_run;
	logic [1:0] status;

	modport source (output valid, output token_kind, output first_char, output second_char,
		output end_of_run, output status, input ready);
	modport sink (input valid, input token_kind, input first_char, input second_char,
		input end_of_run, input status, output ready);
endinterface

// File: hdl/infix_to_postfix_converter.sv
// Top level of the infix to postfix converter: joins the controller and the datapath.
// Depends on ipc_pkg, ipc_char_if, ipc_tok_if, ipc_controller and ipc_datapath.
//
//   channel   direction   payload                                             request
//   chars     in          ch, final_char                                      one character
//   tokens    out         token_kind, first_char, second_char,                one postfix token
//                         end_of_run, status
//
// A digit, letter, opening bracket or ignored character passes through decode back to idle.
// A closing bracket or operator also walks a pop loop over the operators and then the flush.
// The last character then goes through the final close, which pops the remaining operators
// and the implicit bracket, then the end check, the end token and the flush.
// The controller walks the operator stack one entry a cycle while the token stream does not stall.
// Reset clears the stack count, the held letter and the status; no clearing pass is needed.
// A stalled token stream holds the controller wherever it next needs to emit.
module infix_to_postfix_converter (
	input logic       clk,
	input logic       arst_n,
	ipc_char_if.sink  chars,
	ipc_tok_if.source tokens
);
	import ipc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ipc_controller u_controller (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (chars.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	ipc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (chars.ch),
		.in_final (chars.final_char),
		.cmd      (cmd),
		.stat     (stat),
		.tokens   (tokens)
	);

endmodule

// File: hdl/ipc_datapath.sv
// Datapath of the infix to postfix converter: operator stack, letter and status
// registers, a one-token holding stage and the output register.
// Depends on ipc_pkg and ipc_tok_if.
module ipc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_ch,
	input  logic              in_final,
	input  ipc_pkg::dp_cmd_t  cmd,
	output ipc_pkg::dp_stat_t stat,
	ipc_tok_if.source         tokens
);
	import ipc_pkg::*;

	logic [7:0]       ch_q;
	logic             fin_q;
	logic [7:0]       stack_q [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_dec;
	logic [7:0]       held_q;
	logic             letter_q;
	logic             inexpr_q;
	status_t          sticky_q;
	status_t          flag_req;
	logic             pend_valid_q;
	tok_kind_t        pend_kind_q;
	logic [7:0]       pend_first_q;
	logic [7:0]       pend_second_q;
	status_t          pend_status_q;
	logic             out_valid_q;
	tok_kind_t        out_kind_q;
	logic [7:0]       out_first_q;
	logic [7:0]       out_second_q;
	logic             out_eor_q;
	status_t          out_status_q;
	logic [7:0]       top_ch;
	logic [7:0]       tok_first;
	logic [7:0]       tok_second;
	logic             stack_full;
	logic             start_expr;
	logic             pend_to_out;

	assign start_expr  = cmd.capture && !inexpr_q;
	assign count_dec   = count_q - 1'b1;
	assign top_ch      = stack_q[count_dec[IDX_W-1:0]];
	assign stack_full  = (count_q >= CNT_W'(STACK_DEPTH));
	assign pend_to_out = pend_valid_q && ((cmd.emit == EMIT_PEND) || cmd.flush);

	always_comb begin
		stat.fin            = fin_q;
		stat.letter_waiting = letter_q;
		stat.is_letter      = is_letter_char(ch_q);
		stat.is_digit       = is_digit_char(ch_q);
		stat.is_open        = is_open_char(ch_q);
		stat.is_close       = is_close_char(ch_q);
		stat.is_op          = (op_prec(ch_q) != PREC_NONE);
		stat.stack_empty    = (count_q == '0);
		stat.top_open       = is_open_char(top_ch);
		stat.top_ge         = (op_prec(top_ch) >= op_prec(ch_q));
		stat.pend_valid     = pend_valid_q;
		stat.slot_free      = !out_valid_q || tokens.ready;
	end

	always_comb begin
		case (cmd.kind)
			TOK_DIGIT: begin
				tok_first  = ch_q;
				tok_second = '0;
			end
			TOK_CELL: begin
				tok_first  = held_q;
				tok_second = ch_q;
			end
			TOK_OP: begin
				tok_first  = top_ch;
				tok_second = '0;
			end
			default: begin
				tok_first  = '0;
				tok_second = '0;
			end
		endcase
	end

	always_comb begin
		flag_req = cmd.flag;
		if (cmd.push_ch && stack_full)
			flag_req = ST_OVERFLOW;
		if (cmd.end_expr && (count_q != '0))
			flag_req = ST_UNMATCHED_OPEN;
	end

	always_ff @(posedge clk) begin
		if (start_expr)
			stack_q[0] <= CH_OPEN_PAREN;
		else if (cmd.push_ch && !stack_full)
			stack_q[count_q[IDX_W-1:0]] <= ch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			held_q       <= '0;
			letter_q     <= 1'b0;
			inexpr_q     <= 1'b0;
			sticky_q     <= ST_OK;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (start_expr) begin
				count_q  <= CNT_W'(1);
				held_q   <= '0;
				letter_q <= 1'b0;
				inexpr_q <= 1'b1;
				sticky_q <= ST_OK;
			end else begin
				if (cmd.push_ch && !stack_full)
					count_q <= count_q + 1'b1;
				else if (cmd.pop)
					count_q <= count_dec;
				else if (cmd.end_expr)
					count_q <= '0;
				if (cmd.hold_letter) begin
					letter_q <= 1'b1;
					held_q   <= ch_q;
				end else if (cmd.drop_letter || cmd.end_expr) begin
					letter_q <= 1'b0;
				end
				if (cmd.end_expr) begin
					held_q   <= '0;
					inexpr_q <= 1'b0;
				end
				if (sticky_q == ST_OK)
					sticky_q <= flag_req;
			end
			if (cmd.emit == EMIT_PEND)
				pend_valid_q <= 1'b1;
			else if (cmd.flush)
				pend_valid_q <= 1'b0;
			if (pend_to_out || (cmd.emit == EMIT_LAST))
				out_valid_q <= 1'b1;
			else if (tokens.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q  <= in_ch;
			fin_q <= in_final;
		end
		if (cmd.emit == EMIT_PEND) begin
			pend_kind_q   <= cmd.kind;
			pend_first_q  <= tok_first;
			pend_second_q <= tok_second;
			pend_status_q <= sticky_q;
		end
		if (cmd.emit == EMIT_LAST) begin
			out_kind_q   <= cmd.kind;
			out_first_q  <= tok_first;
			out_second_q <= tok_second;
			out_status_q <= sticky_q;
			out_eor_q    <= 1'b1;
		end else if (pend_to_out) begin
			out_kind_q   <= pend_kind_q;
			out_first_q  <= pend_first_q;
			out_second_q <= pend_second_q;
			out_status_q <= pend_status_q;
			out_eor_q    <= cmd.flush;
		end
	end

	assign tokens.valid       = out_valid_q;
	assign tokens.token_kind  = out_kind_q;
	assign tokens.first_char  = out_first_q;
	assign tokens.second_char = out_second_q;
	assign tokens.end_of_run  = out_eor_q;
	assign tokens.status      = out_status_q;

endmodule

// File: hdl/ipc_controller.sv
// Controller of the infix to postfix converter: a state machine that walks each
// character through decode, pop loops, the final close and the end token.
// Depends on ipc_pkg.
module ipc_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output ipc_pkg::dp_cmd_t  cmd,
	input  ipc_pkg::dp_stat_t stat
);
	import ipc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_CLOSE,
		S_OPPOP,
		S_FCLOSE,
		S_FCHK,
		S_FEND,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t close_next;
	logic   pend_ok;

	assign in_ready = (state_q == S_IDLE);
	assign pend_ok  = !stat.pend_valid || stat.slot_free;

	always_comb begin
		if (state_q == S_FCLOSE)
			close_next = S_FCHK;
		else if (stat.fin)
			close_next = S_FCLOSE;
		else
			close_next = S_FLUSH;
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.letter_waiting || stat.is_digit) begin
					cmd.kind = stat.letter_waiting ? TOK_CELL : TOK_DIGIT;
					if (stat.fin) begin
						cmd.drop_letter = 1'b1;
						cmd.emit        = EMIT_PEND;
						state_d         = S_FCLOSE;
					end else if (stat.slot_free) begin
						cmd.drop_letter = 1'b1;
						cmd.emit        = EMIT_LAST;
						state_d         = S_IDLE;
					end
				end else if (stat.is_letter) begin
					if (stat.fin) begin
						cmd.flag = ST_UNMATCHED_OPEN;
						state_d  = S_FCLOSE;
					end else begin
						cmd.hold_letter = 1'b1;
						state_d         = S_IDLE;
					end
				end else if (stat.is_open) begin
					cmd.push_ch = 1'b1;
					state_d     = stat.fin ? S_FCLOSE : S_IDLE;
				end else if (stat.is_close) begin
					state_d = S_CLOSE;
				end else if (stat.is_op) begin
					state_d = S_OPPOP;
				end else begin
					state_d = stat.fin ? S_FCLOSE : S_IDLE;
				end
			end
			S_CLOSE, S_FCLOSE: begin
				cmd.kind = TOK_OP;
				if (stat.stack_empty) begin
					cmd.flag = ST_UNMATCHED_CLOSE;
					state_d  = close_next;
				end else if (stat.top_open) begin
					cmd.pop = 1'b1;
					state_d = close_next;
				end else if (pend_ok) begin
					cmd.pop  = 1'b1;
					cmd.emit = EMIT_PEND;
				end
			end
			S_OPPOP: begin
				cmd.kind = TOK_OP;
				if (!stat.stack_empty && stat.top_ge) begin
					if (pend_ok) begin
						cmd.pop  = 1'b1;
						cmd.emit = EMIT_PEND;
					end
				end else begin
					cmd.push_ch = 1'b1;
					state_d     = stat.fin ? S_FCLOSE : S_FLUSH;
				end
			end
			S_FCHK: begin
				cmd.end_expr = 1'b1;
				state_d      = S_FEND;
			end
			S_FEND: begin
				cmd.kind = TOK_END;
				if (pend_ok) begin
					cmd.emit = EMIT_PEND;
					state_d  = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = S_IDLE;
				end else if (stat.slot_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/ipc_checker.sv
// Port-level checker for the infix to postfix converter, bound to the top level.
// Depends on ipc_pkg and infix_to_postfix_converter_defines.svh.
`include "infix_to_postfix_converter_defines.svh"

module ipc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_first,
	input logic [7:0] out_second,
	input logic       out_eor,
	input logic [1:0] out_status
);
	import ipc_pkg::*;

	`IPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_first) && $stable(out_second) && $stable(out_eor) && $stable(out_status))

	`IPC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	`IPC_ASSERT_NOW(a_end_token_last, clk, arst_n, out_valid && (out_kind == TOK_END), out_eor && (out_first == 8'd0) && (out_second == 8'd0))

	`IPC_ASSERT_NOW(a_second_only_cell, clk, arst_n, out_valid && (out_kind != TOK_CELL), out_second == 8'd0)

endmodule

bind infix_to_postfix_converter ipc_checker u_ipc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (chars.valid),
	.in_ready   (chars.ready),
	.out_valid  (tokens.valid),
	.out_ready  (tokens.ready),
	.out_kind   (tokens.token_kind),
	.out_first  (tokens.first_char),
	.out_second (tokens.second_char),
	.out_eor    (tokens.end_of_run),
	.out_status (tokens.status)
);
